FILE: rtl/ami_pkg.sv
// Package for the almost Montgomery inverse pipeline.
// Holds word sizes, the status codes, the per-stage record and the one-step function.
// Depends on nothing; used by almost_montgomery_inverse.
package ami_pkg;

   // Working word width of u, v, r and s, and the number of step stages.
   localparam int WORD_BITS = 16;
   localparam int MAX_STEPS = 64;

   // Field widths fixed by the interface.
   localparam int MOD_W    = 15;
   localparam int VALUE_W  = 15;
   localparam int INV_W    = 16;
   localparam int STEP_W   = 7;
   localparam int STATUS_W = 2;

   // Byte address of the modulus register on the configuration port.
   localparam logic [2:0] MODULUS_ADDR = 3'd0;

   // Step counter width, wide enough to hold MAX_STEPS itself.
   localparam int K_W = $clog2(MAX_STEPS + 1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_LIMIT = 2'd2
   } status_type;

   typedef logic [WORD_BITS-1:0] word_type;

   // State of one item as it moves down the pipeline.
   typedef struct packed {
      logic       done;
      status_type status;
      word_type   u;
      word_type   v;
      word_type   r;
      word_type   s;
      logic [K_W-1:0] k;
   } stage_type;

   // Arithmetic halving of a two's complement word.
   function automatic word_type half_arith(word_type x);
      half_arith = {x[WORD_BITS-1], x[WORD_BITS-1:1]};
   endfunction

   // Doubling with wrap.
   function automatic word_type twice(word_type x);
      twice = {x[WORD_BITS-2:0], 1'b0};
   endfunction

   // One step of the subtraction-free loop; a finished item passes unchanged.
   function automatic stage_type step_fn(stage_type st);
      stage_type nx;
      word_type  x;
      word_type  y;
      nx = st;
      x  = st.u + st.v;
      y  = st.r + st.s;
      if (!st.done) begin
         if (!st.u[0]) begin
            nx.u = half_arith(st.u);
            nx.s = twice(st.s);
            nx.k = st.k + K_W'(1);
         end else if (!st.v[0]) begin
            nx.v = half_arith(st.v);
            nx.r = twice(st.r);
            nx.k = st.k + K_W'(1);
         end else if (x == '0) begin
            nx.done   = 1'b1;
            nx.status = STATUS_DONE;
         end else if (x[WORD_BITS-1]) begin
            nx.u = half_arith(x);
            nx.r = y;
            nx.s = twice(st.s);
            nx.k = st.k + K_W'(1);
         end else begin
            nx.v = half_arith(x);
            nx.s = y;
            nx.r = twice(st.r);
            nx.k = st.k + K_W'(1);
         end
      end
      step_fn = nx;
   endfunction

endpackage

FILE: rtl/almost_montgomery_inverse.sv
// Almost Montgomery inverse, one loop step per pipeline stage.
// Path from input accept to result valid: entry stage, MAX_STEPS step stages, output register.
// Throughput: one item per cycle; a stalled result stalls the whole pipeline.
// Every item passes through all MAX_STEPS step stages, whatever its step count.
// Synchronous active-high reset clears all valid bits and sets the modulus to 1.
// Uses ami_pkg for widths, status codes and the step function.
module almost_montgomery_inverse
   import ami_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [14:0] value, [15] zero
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] almost_inverse, [22:16] step_count, [23] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Modulus register.
   logic [MOD_W-1:0] modulus_ff;
   logic [MOD_W-1:0] modulus_in;
   logic             csr_write;

   // Pipeline stage zero holds the initial state, stages 1..MAX_STEPS the steps.
   stage_type        pipe_ff    [0:MAX_STEPS];
   stage_type        pipe_in    [0:MAX_STEPS];
   logic             valid_ff   [0:MAX_STEPS];
   logic             valid_in   [0:MAX_STEPS];

   // Output register.
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [INV_W-1:0] inv_ff;
   logic [INV_W-1:0] inv_in;
   logic [STEP_W-1:0] steps_ff;
   logic [STEP_W-1:0] steps_in;
   status_type       status_ff;
   status_type       status_in;

   logic             advance;
   logic [VALUE_W-1:0] value;
   logic             out_of_range;

   // The whole pipeline moves unless a result waits and is not taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Configuration writes and reads.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == MODULUS_ADDR[2]);
   assign csr_prdata = (csr_paddr[2] == MODULUS_ADDR[2]) ?
                       {{(32-MOD_W){1'b0}}, modulus_ff} : '0;

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_write) begin
         modulus_in = csr_pwdata[MOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_W'(1);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   // Entry stage: range check and initial u, v, r, s.
   assign value        = req_tdata[VALUE_W-1:0];
   assign out_of_range = (value == '0) || (value > modulus_ff);

   always_comb begin
      valid_in[0]       = req_tvalid;
      pipe_in[0].done   = out_of_range;
      pipe_in[0].status = out_of_range ? STATUS_RANGE : STATUS_DONE;
      pipe_in[0].u      = word_type'(0) - word_type'(modulus_ff);
      pipe_in[0].v      = word_type'(value);
      pipe_in[0].r      = '0;
      pipe_in[0].s      = word_type'(1);
      pipe_in[0].k      = '0;
   end

   // Step stages: one loop step each.
   for (genvar i = 1; i <= MAX_STEPS; i++) begin : g_step
      always_comb begin
         valid_in[i] = valid_ff[i-1];
         pipe_in[i]  = step_fn(pipe_ff[i-1]);
      end
   end

   // Result formatting: an unfinished item hit the step limit.
   always_comb begin
      rsp_valid_in = valid_ff[MAX_STEPS];
      status_in    = pipe_ff[MAX_STEPS].done ? pipe_ff[MAX_STEPS].status : STATUS_LIMIT;
      inv_in       = INV_W'($signed(pipe_ff[MAX_STEPS].r));
      steps_in     = STEP_W'(pipe_ff[MAX_STEPS].k);
   end

   // Pipeline registers; valid bits are reset, payload is not.
   for (genvar i = 0; i <= MAX_STEPS; i++) begin : g_regs
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= valid_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         inv_ff    <= inv_in;
         steps_ff  <= steps_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, steps_ff, inv_ff};
   assign rsp_tuser  = status_ff;

`ifndef SYNTHESIS
   // A range error carries a zero inverse and a zero step count.
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_RANGE) |-> (inv_ff == '0) && (steps_ff == '0))
      else $error("range error result carries nonzero fields");

   // A step limit result reports exactly MAX_STEPS steps.
   a_limit_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_LIMIT) |-> (steps_ff == STEP_W'(MAX_STEPS)))
      else $error("step limit result with wrong step count");

   // A finished run ends before the step limit.
   a_done_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_DONE) |-> (steps_ff < STEP_W'(MAX_STEPS)))
      else $error("finished run reports too many steps");

   // A waiting result blocks new input items.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted while result stalled");

   // Reset empties the output stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");
`endif

endmodule
